// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked on every rising clock edge outside reset.
`define CAU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define CAU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/cau_pkg.sv =====
`default_nettype none

package cau_pkg;

  localparam int DATA_W = 32;
  localparam int WIDE_W = 66;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_t;

  localparam logic signed [WIDE_W-1:0] MAX_V = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] MIN_V = -66'sd2147483648;

  function automatic sat_t saturate(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > MAX_V) begin
      r.val = 32'h7FFF_FFFF;
      r.ovf = 1'b1;
    end else if (v < MIN_V) begin
      r.val = 32'h8000_0000;
      r.ovf = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cau_div_step.sv =====
`default_nettype none

module cau_div_step (
  input  wire logic [63:0] rem,
  input  wire logic        nbit,
  input  wire logic [63:0] den,
  input  wire logic [31:0] q,
  output logic      [63:0] rem_next,
  output logic      [31:0] q_next
);

  logic [64:0] trial;
  logic        ge;

  always_comb begin
    trial    = {rem, nbit};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? 64'(trial - {1'b0, den}) : trial[63:0];
    q_next   = {q[30:0], ge};
  end

endmodule

`default_nettype wire

// ===== sv/complex_arithmetic_unit_core.sv =====
// Complex add, subtract, multiply and divide on signed fixed-point operands with
// FRAC_BITS fraction bits. One transfer is accepted in every cycle while the output
// is not stalled, and results are presented in the order their operands were
// accepted; the depth is set by the 32-step restoring divide pipeline plus the
// product, sum and setup stages and the output register, and every operation
// passes through it so that results keep their order. A stall on the output holds
// the pipeline. Divide truncates toward zero, out-of-range parts saturate and set
// overflow, and a zero divisor gives zero with div_by_zero set.
`default_nettype none

`include "assert_macros.svh"

module complex_arithmetic_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // a_re, a_im, b_re, b_im
  input  wire logic [127:0] s_tdata,
  // opcode
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // res_re, res_im
  output logic [63:0]       m_tdata,
  // overflow, div_by_zero
  output logic [1:0]        m_tuser
);

  localparam int NW    = 64 + FRAC_BITS;
  localparam int STEPS = 32;
  localparam int NS    = STEPS + 4;
  localparam logic signed [65:0] BIAS = (66'sd1 <<< FRAC_BITS) - 66'sd1;

  typedef struct packed {
    cau_pkg::opcode_t  op;
    logic              dz;
    logic signed [65:0] val_re;
    logic signed [65:0] val_im;
    logic [63:0]       den;
    logic [NW-1:0]     n_re;
    logic [NW-1:0]     n_im;
    logic [63:0]       rem_re;
    logic [63:0]       rem_im;
    logic [31:0]       q_re;
    logic [31:0]       q_im;
    logic              neg_re;
    logic              neg_im;
    logic              sat_re;
    logic              sat_im;
  } dv_t;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = m_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[0];

  logic signed [31:0] in_a, in_b, in_c, in_d;
  assign in_a = s_tdata[31:0];
  assign in_b = s_tdata[63:32];
  assign in_c = s_tdata[95:64];
  assign in_d = s_tdata[127:96];

  cau_pkg::opcode_t   a_op;
  logic signed [63:0] p_ac, p_bd, p_ad, p_bc, p_cc, p_dd;
  logic signed [32:0] as_re, as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= s_tvalid;
    end
    if (rdy[0]) begin
      a_op <= cau_pkg::opcode_t'(s_tuser);
      p_ac <= in_a * in_c;
      p_bd <= in_b * in_d;
      p_ad <= in_a * in_d;
      p_bc <= in_b * in_c;
      p_cc <= in_c * in_c;
      p_dd <= in_d * in_d;
      if (cau_pkg::opcode_t'(s_tuser) == cau_pkg::OP_SUB) begin
        as_re <= 33'(in_a) - 33'(in_c);
        as_im <= 33'(in_b) - 33'(in_d);
      end else begin
        as_re <= 33'(in_a) + 33'(in_c);
        as_im <= 33'(in_b) + 33'(in_d);
      end
    end
  end

  cau_pkg::opcode_t   b_op;
  logic signed [65:0] s_re, s_im;
  logic [63:0]        b_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[1] <= 1'b0;
    end else if (rdy[1]) begin
      v[1] <= v[0];
    end
    if (rdy[1]) begin
      b_op  <= a_op;
      b_den <= $unsigned(p_cc) + $unsigned(p_dd);
      unique case (a_op)
        cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
          s_re <= 66'(as_re);
          s_im <= 66'(as_im);
        end
        cau_pkg::OP_MUL: begin
          s_re <= 66'(p_ac) - 66'(p_bd);
          s_im <= 66'(p_ad) + 66'(p_bc);
        end
        cau_pkg::OP_DIV: begin
          s_re <= 66'(p_ac) + 66'(p_bd);
          s_im <= 66'(p_bc) - 66'(p_ad);
        end
        default: begin
          s_re <= '0;
          s_im <= '0;
        end
      endcase
    end
  end

  dv_t dst [0:STEPS];
  dv_t c_next;
  logic [65:0] mag_re, mag_im;

  always_comb begin
    c_next        = '0;
    c_next.op     = b_op;
    c_next.dz     = b_den == 64'd0;
    c_next.den    = b_den;
    c_next.neg_re = s_re[65];
    c_next.neg_im = s_im[65];
    mag_re        = s_re[65] ? 66'(-s_re) : 66'(s_re);
    mag_im        = s_im[65] ? 66'(-s_im) : 66'(s_im);
    c_next.n_re   = NW'(mag_re[63:0]) << FRAC_BITS;
    c_next.n_im   = NW'(mag_im[63:0]) << FRAC_BITS;
    c_next.rem_re = 64'(c_next.n_re[NW-1:32]);
    c_next.rem_im = 64'(c_next.n_im[NW-1:32]);
    c_next.sat_re = c_next.rem_re >= b_den;
    c_next.sat_im = c_next.rem_im >= b_den;
    if (b_op == cau_pkg::OP_MUL) begin
      c_next.val_re = (s_re + (s_re[65] ? BIAS : 66'sd0)) >>> FRAC_BITS;
      c_next.val_im = (s_im + (s_im[65] ? BIAS : 66'sd0)) >>> FRAC_BITS;
    end else begin
      c_next.val_re = s_re;
      c_next.val_im = s_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[2] <= 1'b0;
    end else if (rdy[2]) begin
      v[2] <= v[1];
    end
    if (rdy[2]) begin
      dst[0] <= c_next;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [63:0] rr, ri;
    logic [31:0] qr, qi;
    dv_t         nx;

    cau_div_step u_re (
      .rem      (dst[k].rem_re),
      .nbit     (dst[k].n_re[STEPS-1-k]),
      .den      (dst[k].den),
      .q        (dst[k].q_re),
      .rem_next (rr),
      .q_next   (qr)
    );

    cau_div_step u_im (
      .rem      (dst[k].rem_im),
      .nbit     (dst[k].n_im[STEPS-1-k]),
      .den      (dst[k].den),
      .q        (dst[k].q_im),
      .rem_next (ri),
      .q_next   (qi)
    );

    always_comb begin
      nx        = dst[k];
      nx.rem_re = rr;
      nx.rem_im = ri;
      nx.q_re   = qr;
      nx.q_im   = qi;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[3+k] <= 1'b0;
      end else if (rdy[3+k]) begin
        v[3+k] <= v[2+k];
      end
      if (rdy[3+k]) begin
        dst[k+1] <= nx;
      end
    end
  end

  dv_t                last;
  logic signed [65:0] f_re, f_im, dm_re, dm_im;
  cau_pkg::sat_t      sr, si;
  logic [31:0]        res_re, res_im;
  logic               ovf, dz;

  always_comb begin
    last  = dst[STEPS];
    dm_re = last.sat_re ? (66'sd1 <<< 32) : 66'(last.q_re);
    dm_im = last.sat_im ? (66'sd1 <<< 32) : 66'(last.q_im);
    if (last.op == cau_pkg::OP_DIV) begin
      if (last.dz) begin
        f_re = '0;
        f_im = '0;
      end else begin
        f_re = last.neg_re ? -dm_re : dm_re;
        f_im = last.neg_im ? -dm_im : dm_im;
      end
    end else begin
      f_re = last.val_re;
      f_im = last.val_im;
    end
    sr = cau_pkg::saturate(f_re);
    si = cau_pkg::saturate(f_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[NS-1] <= 1'b0;
    end else if (rdy[NS-1]) begin
      v[NS-1] <= v[NS-2];
    end
    if (rdy[NS-1]) begin
      res_re <= sr.val;
      res_im <= si.val;
      ovf    <= sr.ovf || si.ovf;
      dz     <= (last.op == cau_pkg::OP_DIV) && last.dz;
    end
  end

  assign m_tvalid = v[NS-1];
  assign m_tdata  = {res_im, res_re};
  assign m_tuser  = {dz, ovf};

  `CAU_ASSERT_IMP(a_dz_zero, clk, rst, m_tvalid && dz, res_re == 32'd0 && res_im == 32'd0 && !ovf)
  `CAU_ASSERT_IMP(a_ovf_sat, clk, rst, m_tvalid && ovf,
                  res_re == 32'h7FFF_FFFF || res_re == 32'h8000_0000 ||
                  res_im == 32'h7FFF_FFFF || res_im == 32'h8000_0000)
  `CAU_ASSERT_IMP(a_empty_ready, clk, rst, !m_tvalid, s_tready)
  `CAU_ASSERT_NXT(a_last_move, clk, rst, v[NS-2] && rdy[NS-1], m_tvalid)

endmodule

`default_nettype wire
